/* hdl/pdf_pkg.sv */
// Package for the sum16 packet deframer: framing states, register indexes,
// field widths and the controller/datapath command and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package pdf_pkg;

	// Fixed field widths
	localparam int BYTE_W  = 8;
	localparam int SIZE_W  = 7;
	localparam int IDX_W   = 6;
	localparam int SUM_W   = 16;
	localparam int CIDX_W  = 2;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_SYNC_BYTE     = 2'd0;
	localparam logic [CIDX_W-1:0] REG_TYPE_LIMIT    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

	// Configuration reset values
	localparam logic [BYTE_W-1:0] SYNC_BYTE_RST     = 8'd0;
	localparam logic [BYTE_W-1:0] TYPE_LIMIT_RST    = 8'd255;
	localparam logic [SIZE_W-1:0] PAYLOAD_LIMIT_RST = 7'd64;

	// Framing phases
	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_TYPE  = 3'd2,
		PH_SIZE  = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUMHI = 3'd5,
		PH_SUMLO = 3'd6,
		PH_EMIT  = 3'd7
	} pdf_phase_t;

	// Controller to datapath
	typedef struct packed {
		logic cap_type;   // latch type, seed the sum
		logic cap_size;   // latch size, clear byte count
		logic wr_data;    // store payload byte, add to sum
		logic cap_sumhi;  // latch checksum high byte
		logic emit_clr;   // restart readout index
		logic emit_load;  // load one result into the output register
	} pdf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sync_match; // rx byte equals sync byte
		logic type_ok;    // rx byte in 1..type_limit
		logic size_ok;    // rx byte within payload limit
		logic rx_zero;    // rx byte is zero
		logic data_done;  // this payload byte is the last one
		logic sum_match;  // received checksum equals running sum
		logic emit_last;  // readout index is on the final result
		logic out_free;   // output register can take a result
	} pdf_stat_t;

endpackage

/* hdl/pdf_ctrl.sv */
// Framing controller for the sum16 packet deframer: phase register and
// command decode. Depends on pdf_pkg.
`timescale 1ns / 1ps

module pdf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pdf_pkg::pdf_stat_t stat,
	output pdf_pkg::pdf_cmd_t  cmd,
	output logic              emitting
);
	import pdf_pkg::*;

	pdf_phase_t state_q;
	pdf_phase_t state_d;
	logic       take;

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_SYNC1;
		end else begin
			state_q <= state_d;
		end
	end

	// Next phase and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q == PH_EMIT);
		emitting = (state_q == PH_EMIT);
		take     = in_valid && !in_stall;
		case (state_q)
			PH_SYNC1: begin
				if (take) begin
					state_d = stat.sync_match ? PH_SYNC2 : PH_SYNC1;
				end
			end
			PH_SYNC2: begin
				if (take) begin
					state_d = stat.sync_match ? PH_TYPE : PH_SYNC1;
				end
			end
			PH_TYPE: begin
				if (take) begin
					if (stat.type_ok) begin
						cmd.cap_type = 1'b1;
						state_d      = PH_SIZE;
					end else begin
						state_d = PH_SYNC1;
					end
				end
			end
			PH_SIZE: begin
				if (take) begin
					if (stat.size_ok) begin
						cmd.cap_size = 1'b1;
						state_d      = stat.rx_zero ? PH_SUMHI : PH_DATA;
					end else begin
						state_d = PH_SYNC1;
					end
				end
			end
			PH_DATA: begin
				if (take) begin
					cmd.wr_data = 1'b1;
					if (stat.data_done) begin
						state_d = PH_SUMHI;
					end
				end
			end
			PH_SUMHI: begin
				if (take) begin
					cmd.cap_sumhi = 1'b1;
					state_d       = PH_SUMLO;
				end
			end
			PH_SUMLO: begin
				if (take) begin
					if (stat.sum_match) begin
						cmd.emit_clr = 1'b1;
						state_d      = PH_EMIT;
					end else begin
						state_d = PH_SYNC1;
					end
				end
			end
			PH_EMIT: begin
				// one result per free output slot
				if (stat.out_free) begin
					cmd.emit_load = 1'b1;
					if (stat.emit_last) begin
						state_d = PH_SYNC1;
					end
				end
			end
			default: begin
				state_d = PH_SYNC1;
			end
		endcase
	end

endmodule

/* hdl/pdf_dp.sv */
// Datapath for the sum16 packet deframer: frame registers, running sum,
// payload memory and the output register. Depends on pdf_pkg.
`timescale 1ns / 1ps

module pdf_dp #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pdf_pkg::BYTE_W-1:0]   rx_byte,
	input  logic [pdf_pkg::BYTE_W-1:0]   sync_byte,
	input  logic [pdf_pkg::BYTE_W-1:0]   type_limit,
	input  logic [pdf_pkg::SIZE_W-1:0]   payload_limit,
	input  pdf_pkg::pdf_cmd_t             cmd,
	output pdf_pkg::pdf_stat_t            stat,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [pdf_pkg::BYTE_W-1:0]   pkt_type,
	output logic [pdf_pkg::SIZE_W-1:0]   pkt_size,
	output logic [pdf_pkg::IDX_W-1:0]    byte_index,
	output logic [pdf_pkg::BYTE_W-1:0]   payload_byte,
	output logic                         has_byte,
	output logic                         last
);
	import pdf_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_PAYLOAD);

	logic [BYTE_W-1:0] frame_type_q;
	logic [SIZE_W-1:0] frame_size_q;
	logic [SIZE_W-1:0] count_q;
	logic [BYTE_W-1:0] sum_hi_q;
	logic [SUM_W-1:0]  sum_q;
	logic [IDX_W-1:0]  emit_idx_q;
	logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_type_q;
	logic [SIZE_W-1:0] out_size_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic              out_has_q;
	logic              out_last_q;

	logic [SIZE_W-1:0] size_lim;
	logic [SIZE_W-1:0] count_inc;
	logic [SIZE_W-1:0] emit_inc;
	logic              pkt_empty;

	// Status decode
	assign size_lim  = (payload_limit > MAX_SIZE) ? MAX_SIZE : payload_limit;
	assign count_inc = count_q + SIZE_W'(1);
	assign emit_inc  = {1'b0, emit_idx_q} + SIZE_W'(1);
	assign pkt_empty = (frame_size_q == '0);

	always_comb begin
		stat.sync_match = (rx_byte == sync_byte);
		stat.type_ok    = (rx_byte != '0) && (rx_byte <= type_limit);
		stat.size_ok    = ({1'b0, size_lim} >= rx_byte);
		stat.rx_zero    = (rx_byte == '0);
		stat.data_done  = (count_inc >= frame_size_q);
		stat.sum_match  = ({sum_hi_q, rx_byte} == sum_q);
		stat.emit_last  = pkt_empty || (emit_inc == frame_size_q);
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// Frame header, byte count and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_type_q <= '0;
			frame_size_q <= '0;
			count_q      <= '0;
			sum_hi_q     <= '0;
			sum_q        <= '0;
			emit_idx_q   <= '0;
		end else begin
			if (cmd.cap_type) begin
				frame_type_q <= rx_byte;
				sum_q        <= {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
			end
			if (cmd.cap_size) begin
				frame_size_q <= rx_byte[SIZE_W-1:0];
				count_q      <= '0;
				sum_q        <= sum_q + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
			end
			if (cmd.wr_data) begin
				count_q <= count_inc;
				sum_q   <= sum_q + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
			end
			if (cmd.cap_sumhi) begin
				sum_hi_q <= rx_byte;
			end
			if (cmd.emit_clr) begin
				emit_idx_q <= '0;
			end else if (cmd.emit_load) begin
				emit_idx_q <= emit_inc[IDX_W-1:0];
			end
		end
	end

	// Payload memory write port
	always_ff @(posedge clk) begin
		if (cmd.wr_data) begin
			payload_mem[count_q[AW-1:0]] <= rx_byte;
		end
	end

	// Registered read port feeds the output register directly
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			rd_data_q  <= payload_mem[emit_idx_q[AW-1:0]];
			out_type_q <= frame_type_q;
			out_size_q <= frame_size_q;
			out_idx_q  <= emit_idx_q;
			out_has_q  <= !pkt_empty;
			out_last_q <= stat.emit_last;
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign pkt_type     = out_type_q;
	assign pkt_size     = out_size_q;
	assign byte_index   = out_idx_q;
	assign payload_byte = out_has_q ? rd_data_q : '0;
	assign has_byte     = out_has_q;
	assign last         = out_last_q;

endmodule

/* hdl/packet_deframer_sum16.sv */
// Top level of the sum16 packet deframer: configuration registers and the
// controller/datapath pair. Depends on pdf_pkg, pdf_ctrl and pdf_dp.
//
//  Channel   Dir  Handshake             Beat contents
//  in        in   in_valid / in_stall   rx_byte
//  out       out  out_valid / out_stall pkt_type, pkt_size, byte_index,
//                                       payload_byte, has_byte, last
//  cfg       in   cfg_we                cfg_index, cfg_data
//
// One received byte is taken per cycle while framing.
// A frame that passes its checksum is read out of the payload memory as
// max(size, 1) results at one result per cycle, set by the single read port;
// in_stall is high for that readout and drops as the last result loads.
// out_stall holds the output register and pauses the readout.
// Reset clears the framing state and loads the register defaults; the payload
// memory is not cleared and needs no pass after reset.
`timescale 1ns / 1ps

module packet_deframer_sum16 #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pdf_pkg::BYTE_W-1:0]   rx_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pdf_pkg::BYTE_W-1:0]   pkt_type,
	output logic [pdf_pkg::SIZE_W-1:0]   pkt_size,
	output logic [pdf_pkg::IDX_W-1:0]    byte_index,
	output logic [pdf_pkg::BYTE_W-1:0]   payload_byte,
	output logic                         has_byte,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic [pdf_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [pdf_pkg::BYTE_W-1:0]   cfg_data
);
	import pdf_pkg::*;

	logic [BYTE_W-1:0] sync_byte_q;
	logic [BYTE_W-1:0] type_limit_q;
	logic [SIZE_W-1:0] payload_limit_q;
	pdf_cmd_t          cmd;
	pdf_stat_t         stat;
	logic              emitting;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q     <= SYNC_BYTE_RST;
			type_limit_q    <= TYPE_LIMIT_RST;
			payload_limit_q <= PAYLOAD_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_BYTE:     sync_byte_q     <= cfg_data;
				REG_TYPE_LIMIT:    type_limit_q    <= cfg_data;
				REG_PAYLOAD_LIMIT: payload_limit_q <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd),
		.emitting (emitting)
	);

	pdf_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.sync_byte     (sync_byte_q),
		.type_limit    (type_limit_q),
		.payload_limit (payload_limit_q),
		.cmd           (cmd),
		.stat          (stat),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.pkt_type      (pkt_type),
		.pkt_size      (pkt_size),
		.byte_index    (byte_index),
		.payload_byte  (payload_byte),
		.has_byte      (has_byte),
		.last          (last)
	);

`ifndef NO_ASSERTIONS
	// Readout only loads results while input is held off
	a_emit_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> emitting && in_stall)
		else $error("result loaded while input open");

	// An empty-packet beat carries size zero and closes the packet
	a_empty_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> last && (pkt_size == '0) && (byte_index == '0))
		else $error("bad empty-packet beat");

	// The final payload beat sits at size minus one
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_byte && last |-> ({1'b0, byte_index} + 7'd1) == pkt_size)
		else $error("last flag on wrong index");

	// Within a packet the next beat follows at once with the next index
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			out_valid && (byte_index == $past(byte_index) + 6'd1))
		else $error("gap or skip in readout");
`endif

endmodule

/* tb/tb_packet_deframer_sum16.sv */
// Self-checking testbench for packet_deframer_sum16: byte frames in, payload beats out.
// Depends on pdf_pkg and the packet_deframer_sum16 RTL; reads no files.
`timescale 1ns / 1ps

module tb_packet_deframer_sum16;
	import pdf_pkg::*;

	localparam int MAX_PL      = 64;
	localparam int GAP_PCT     = 31;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYC  = 8;
	localparam int MAX_REPORTS = 10;
	// index past the register list; writes to it must be ignored
	localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		byte_t             ptype;
		logic [SIZE_W-1:0] psize;
		logic [IDX_W-1:0]  idx;
		byte_t             data;
		logic              has;
		logic              last;
	} pkt_beat_t;

	// DUT connections, all inputs driven from time zero
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	byte_t               rx_byte   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	byte_t               pkt_type;
	logic [SIZE_W-1:0]   pkt_size;
	logic [IDX_W-1:0]    byte_index;
	byte_t               payload_byte;
	logic                has_byte;
	logic                last;
	logic                cfg_we    = 1'b0;
	logic [CIDX_W-1:0]   cfg_index = '0;
	byte_t               cfg_data  = '0;

	// Register mirror and framing state of the predictor
	byte_t               sync_val;
	byte_t               tlim_val;
	logic [SIZE_W-1:0]   plim_val;
	pdf_phase_t          fr_phase;
	byte_t               fr_type;
	logic [SIZE_W-1:0]   fr_size;
	logic [SIZE_W-1:0]   fr_count;
	byte_t               fr_sumhi;
	logic [SUM_W-1:0]    fr_sum;
	byte_t               fr_store [MAX_PL];

	pkt_beat_t           beats_due[$];
	int                  err_count  = 0;
	int                  cycles     = 0;
	int                  item_count = 0;
	bit                  gaps_on    = 1'b1;

	packet_deframer_sum16 #(.MAX_PAYLOAD(MAX_PL)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pkt_type     (pkt_type),
		.pkt_size     (pkt_size),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.has_byte     (has_byte),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Random back-pressure on the result channel
	always @(negedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
	end

	function automatic byte_t eff_limit();
		return (plim_val > MAX_PL) ? byte_t'(MAX_PL) : byte_t'(plim_val);
	endfunction

	// Queue the beats of an accepted packet
	function automatic void emit_packet();
		pkt_beat_t b;
		int k;
		b.ptype = fr_type;
		if (fr_size == 0) begin
			b.psize = '0;
			b.idx   = '0;
			b.data  = '0;
			b.has   = 1'b0;
			b.last  = 1'b1;
			beats_due.push_back(b);
		end else begin
			for (k = 0; k < fr_size; k++) begin
				b.psize = fr_size;
				b.idx   = k[IDX_W-1:0];
				b.data  = fr_store[k];
				b.has   = 1'b1;
				b.last  = (k == fr_size - 1);
				beats_due.push_back(b);
			end
		end
	endfunction

	// Framing state machine: advance by one received byte
	function automatic void frame_advance(byte_t c);
		case (fr_phase)
			PH_SYNC2: begin
				fr_phase = (c == sync_val) ? PH_TYPE : PH_SYNC1;
			end
			PH_TYPE: begin
				if (c != 0 && c <= tlim_val) begin
					fr_type  = c;
					fr_sum   = SUM_W'(c);
					fr_phase = PH_SIZE;
				end else begin
					fr_phase = PH_SYNC1;
				end
			end
			PH_SIZE: begin
				if (c > eff_limit()) begin
					fr_phase = PH_SYNC1;
				end else begin
					fr_size  = c[SIZE_W-1:0];
					fr_count = '0;
					fr_sum   = fr_sum + SUM_W'(c);
					fr_phase = (c != 0) ? PH_DATA : PH_SUMHI;
				end
			end
			PH_DATA: begin
				if (fr_count < MAX_PL)
					fr_store[fr_count] = c;
				fr_sum   = fr_sum + SUM_W'(c);
				fr_count = fr_count + 1'b1;
				if (fr_count >= fr_size)
					fr_phase = PH_SUMHI;
			end
			PH_SUMHI: begin
				fr_sumhi = c;
				fr_phase = PH_SUMLO;
			end
			PH_SUMLO: begin
				fr_phase = PH_SYNC1;
				if ({fr_sumhi, c} == fr_sum)
					emit_packet();
			end
			default: begin
				fr_phase = (c == sync_val) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	endfunction

	// Result checker: each accepted beat against the oldest expectation
	always @(posedge clk) begin
		pkt_beat_t got;
		pkt_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.ptype = pkt_type;
			got.psize = pkt_size;
			got.idx   = byte_index;
			got.data  = payload_byte;
			got.has   = has_byte;
			got.last  = last;
			if (beats_due.size() == 0) begin
				if (err_count < MAX_REPORTS)
					$display("unexpected beat: type=%0d size=%0d idx=%0d byte=%02h has=%0b last=%0b",
						got.ptype, got.psize, got.idx, got.data, got.has, got.last);
				err_count++;
			end else begin
				want = beats_due.pop_front();
				if (got.ptype !== want.ptype || got.psize !== want.psize ||
				    got.idx !== want.idx || got.data !== want.data ||
				    got.has !== want.has || got.last !== want.last) begin
					if (err_count < MAX_REPORTS) begin
						$display("mismatch exp: type=%0d size=%0d idx=%0d byte=%02h has=%0b last=%0b",
							want.ptype, want.psize, want.idx, want.data, want.has, want.last);
						$display("         got: type=%0d size=%0d idx=%0d byte=%02h has=%0b last=%0b",
							got.ptype, got.psize, got.idx, got.data, got.has, got.last);
					end
					err_count++;
				end
			end
		end
	end

	// One input beat; called and returns at a falling edge
	task automatic send_byte(byte_t c);
		while (gaps_on && $urandom_range(99) < GAP_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		frame_advance(c);
		item_count++;
		@(negedge clk);
	endtask

	// Stop sending, wait for every expected beat, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (beats_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// Register write; only issued while the block is idle
	task automatic write_reg(logic [CIDX_W-1:0] idx, byte_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_SYNC_BYTE:     sync_val = val;
			REG_TYPE_LIMIT:    tlim_val = val;
			REG_PAYLOAD_LIMIT: plim_val = val[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	// Complete frame with random payload; optionally a corrupted checksum
	task automatic send_frame(byte_t ptype, int size, bit bad_sum);
		logic [SUM_W-1:0] sum;
		byte_t d;
		send_byte(sync_val);
		send_byte(sync_val);
		send_byte(ptype);
		send_byte(byte_t'(size));
		sum = SUM_W'(ptype) + SUM_W'(size);
		for (int i = 0; i < size; i++) begin
			d   = byte_t'($urandom_range(255));
			sum = sum + SUM_W'(d);
			send_byte(d);
		end
		if (bad_sum)
			sum = sum ^ SUM_W'($urandom_range(1, 16'hFFFF));
		send_byte(sum[15:8]);
		send_byte(sum[7:0]);
	endtask

	// Header broken at the second sync byte, the type, or the size
	task automatic send_broken(int kind);
		send_byte(sync_val);
		case (kind)
			0: send_byte(sync_val ^ byte_t'($urandom_range(1, 255)));
			1: begin
				send_byte(sync_val);
				if (tlim_val == 8'hFF || $urandom_range(3) == 0)
					send_byte(8'h00);
				else
					send_byte(byte_t'($urandom_range(tlim_val + 1, 255)));
			end
			default: begin
				send_byte(sync_val);
				send_byte(byte_t'($urandom_range(1, tlim_val)));
				send_byte(byte_t'($urandom_range(eff_limit() + 1, 255)));
			end
		endcase
	endtask

	function automatic byte_t pick_type();
		case ($urandom_range(3))
			0: return 8'd1;
			1: return tlim_val;
			default: return byte_t'($urandom_range(1, tlim_val));
		endcase
	endfunction

	function automatic int pick_size();
		byte_t lim;
		lim = eff_limit();
		if ($urandom_range(9) == 0)
			return $urandom_range(0, lim);
		return $urandom_range(0, (lim < 6) ? lim : 6);
	endfunction

	// Mostly well-formed frames, with corrupt sums, broken headers and line noise
	task automatic run_traffic(int n_items);
		int stop_at;
		int r;
		int saved;
		stop_at = item_count + n_items;
		while (item_count < stop_at) begin
			r = $urandom_range(99);
			if (r < 70) begin
				send_frame(pick_type(), pick_size(), 1'b0);
			end else if (r < 80) begin
				send_frame(pick_type(), pick_size(), 1'b1);
			end else if (r < 90) begin
				send_broken($urandom_range(2));
			end else begin
				// noise bytes mostly fall on the idle hunt and do not count
				saved = item_count;
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(2) == 0)
						send_byte(sync_val);
					else
						send_byte(byte_t'($urandom_range(255)));
				end
				item_count = saved;
			end
		end
	endtask

	// Register defaults: zero sync, largest type, empty and one-byte packets
	task automatic test_defaults();
		send_frame(8'hFF, 0, 1'b0);
		send_frame(8'h01, 1, 1'b0);
		settle();
	endtask

	// Each header reject and a checksum mismatch, all dropped silently, then a lowered type limit
	task automatic test_header_rejects();
		send_broken(0);
		send_broken(1);
		send_broken(2);
		send_frame(8'h01, 2, 1'b1);
		settle();
		write_reg(REG_TYPE_LIMIT, 8'd10);
		send_broken(1);
		send_frame(8'd10, 0, 1'b0);
		settle();
	endtask

	// Register extremes, the ignored register index and an oversized payload limit
	task automatic test_register_limits();
		write_reg(REG_SYNC_BYTE, 8'hFF);
		write_reg(REG_TYPE_LIMIT, 8'd1);
		write_reg(REG_PAYLOAD_LIMIT, 8'd0);
		send_frame(8'd1, 0, 1'b0);
		send_broken(1);
		send_broken(2);
		settle();
		// zero type limit rejects everything; stray index leaves sync alone
		write_reg(REG_TYPE_LIMIT, 8'd0);
		write_reg(REG_UNUSED, 8'h5A);
		send_frame(8'd1, 0, 1'b0);
		settle();
		// limit above buffer depth clamps to the depth
		write_reg(REG_TYPE_LIMIT, 8'hFF);
		write_reg(REG_PAYLOAD_LIMIT, 8'd100);
		send_byte(sync_val);
		send_byte(sync_val);
		send_byte(8'd1);
		send_byte(8'd65);
		settle();
	endtask

	// Random traffic under several register settings
	task automatic test_random_traffic();
		gaps_on = 1'b1;
		write_reg(REG_SYNC_BYTE, byte_t'($urandom_range(255)));
		write_reg(REG_PAYLOAD_LIMIT, 8'hFF);
		send_frame(pick_type(), MAX_PL, 1'b0);
		run_traffic(15);
		settle();

		// stretch with no gaps or stalls on either side
		gaps_on = 1'b0;
		write_reg(REG_SYNC_BYTE, byte_t'($urandom_range(255)));
		write_reg(REG_TYPE_LIMIT, byte_t'($urandom_range(1, 255)));
		write_reg(REG_PAYLOAD_LIMIT, byte_t'($urandom_range(1, 16)));
		run_traffic(25);
		settle();

		gaps_on = 1'b1;
		write_reg(REG_SYNC_BYTE, 8'hFF);
		write_reg(REG_TYPE_LIMIT, 8'd1);
		write_reg(REG_PAYLOAD_LIMIT, 8'd8);
		run_traffic(15);
		settle();

		write_reg(REG_SYNC_BYTE, byte_t'($urandom_range(255)));
		write_reg(REG_TYPE_LIMIT, 8'hFF);
		write_reg(REG_PAYLOAD_LIMIT, byte_t'(MAX_PL));
		run_traffic(15);
		settle();
	endtask

	initial begin
		sync_val = SYNC_BYTE_RST;
		tlim_val = TYPE_LIMIT_RST;
		plim_val = PAYLOAD_LIMIT_RST;
		fr_phase = PH_SYNC1;
		fr_type  = '0;
		fr_size  = '0;
		fr_count = '0;
		fr_sumhi = '0;
		fr_sum   = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_defaults();
		test_header_rejects();
		test_register_limits();
		test_random_traffic();

		repeat (SETTLE_CYC) @(negedge clk);
		if (beats_due.size() != 0)
			err_count++;
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
